// ===== sv/tlms_pkg.sv =====
// Package for the tile local median subtract block.
// Holds the word types of both channels and the fixed field widths.
// No dependencies.
package tlms_pkg;

  localparam int COORD_W = 8;
  localparam int PIX_W   = 16;
  localparam int RAD_W   = 4;
  localparam int CORR_W  = 17;
  localparam int CNT_W   = 9;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    action_t                   action;
    logic [COORD_W-1:0]        col;
    logic [COORD_W-1:0]        row;
    logic signed [PIX_W-1:0]   pixel_value;
  } req_t;

  typedef struct packed {
    logic signed [CORR_W-1:0]  corrected;
    logic signed [PIX_W-1:0]   background;
    logic [CNT_W-1:0]          window_count;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CADDR,
    ST_CDATA,
    ST_SWEEP,
    ST_DRAIN,
    ST_FIN
  } rank_state_t;

endpackage

// ===== sv/tlms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tlms_rank.sv =====
// Query sequencer: reads the centre pixel, then sweeps the clipped window
// once per result bit and builds the median by radix selection.
// Depends on tlms_pkg.
module tlms_rank import tlms_pkg::*; #(
  parameter int TILE_W     = 194,
  parameter int TILE_H     = 185,
  parameter int MAX_RADIUS = 8,
  localparam int AW        = $clog2(TILE_W * TILE_H)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [COORD_W-1:0]  col,
  input  logic [COORD_W-1:0]  row,
  input  logic [RAD_W-1:0]    radius,
  output logic                busy,
  output logic                done,
  input  logic                take,
  output res_t                res,
  output logic [AW-1:0]       rd_addr,
  input  logic [PIX_W-1:0]    rd_data
);

  localparam int SW = $clog2(2 * MAX_RADIUS + 2);
  localparam int CW = 2 * SW;
  localparam logic [PIX_W-1:0] SIGN = {1'b1, {(PIX_W-1){1'b0}}};

  rank_state_t state, state_next;

  logic [COORD_W-1:0] qcol, qrow, x0, x1, y0, y1, x, y;
  logic [AW-1:0]      base, base0;
  logic               oot, dis, pend;
  logic [PIX_W-1:0]   centre, prefix, mask, cur;
  logic [CW-1:0]      count, k, c0;

  // Window bounds for a new query.
  logic [RAD_W-1:0]   r_eff;
  logic [COORD_W:0]   col_lo, col_hi, row_lo, row_hi;
  logic [COORD_W-1:0] nx0, nx1, ny0, ny1;
  logic [SW-1:0]      span_x, span_y;

  always_comb begin
    r_eff  = ({1'b0, radius} > 5'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
    col_lo = {1'b0, col} - {5'd0, r_eff};
    col_hi = {1'b0, col} + {5'd0, r_eff};
    row_lo = {1'b0, row} - {5'd0, r_eff};
    row_hi = {1'b0, row} + {5'd0, r_eff};
    nx0    = ({1'b0, col} < {5'd0, r_eff}) ? '0 : col_lo[COORD_W-1:0];
    ny0    = ({1'b0, row} < {5'd0, r_eff}) ? '0 : row_lo[COORD_W-1:0];
    nx1    = (col_hi > 9'(TILE_W - 1)) ? COORD_W'(TILE_W - 1) : col_hi[COORD_W-1:0];
    ny1    = (row_hi > 9'(TILE_H - 1)) ? COORD_W'(TILE_H - 1) : row_hi[COORD_W-1:0];
    span_x = SW'(nx1 - nx0 + 8'd1);
    span_y = SW'(ny1 - ny0 + 8'd1);
  end

  // The shared multiplier forms the centre address and the first row base.
  logic [COORD_W-1:0] mul_y;
  logic [AW-1:0]      prod;
  assign mul_y = (state == ST_CADDR) ? qrow : y0;
  assign prod  = AW'(mul_y * TILE_W);

  logic [PIX_W-1:0] biased;
  logic             hit, last;
  logic [CW-1:0]    total;
  assign biased = rd_data ^ SIGN;
  assign hit    = pend && (((biased ^ prefix) & mask) == '0) && ((biased & cur) == '0);
  assign total  = c0 + CW'(hit);
  assign last   = (x == x1) && (y == y1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_CADDR;
      ST_CADDR: state_next = ST_CDATA;
      ST_CDATA: state_next = (oot || dis) ? ST_FIN : ST_SWEEP;
      ST_SWEEP: if (last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = cur[0] ? ST_FIN : ST_SWEEP;
      ST_FIN:   if (take) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state != ST_IDLE);
    done    = (state == ST_FIN);
    rd_addr = (state == ST_CADDR) ? AW'(prod + AW'(qcol)) : AW'(base + AW'(x));
    res     = '0;
    if (!oot) begin
      if (dis) begin
        res.corrected = CORR_W'($signed(centre));
      end else begin
        res.background   = prefix ^ SIGN;
        res.corrected    = CORR_W'($signed(centre)) - CORR_W'($signed(prefix ^ SIGN));
        res.window_count = CNT_W'(count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_SWEEP);
    end
    case (state)
      ST_IDLE: begin
        if (start) begin
          qcol  <= col;
          qrow  <= row;
          x0    <= nx0;
          x1    <= nx1;
          y0    <= ny0;
          y1    <= ny1;
          oot   <= ({1'b0, col} >= 9'(TILE_W)) || ({1'b0, row} >= 9'(TILE_H));
          dis   <= (radius == '0) || (8'(radius) >= 8'(TILE_H / 2));
          count <= CW'(span_x * span_y);
        end
      end
      ST_CDATA: begin
        centre <= rd_data;
        base0  <= prod;
        base   <= prod;
        x      <= x0;
        y      <= y0;
        prefix <= '0;
        mask   <= '0;
        cur    <= SIGN;
        k      <= count >> 1;
        c0     <= '0;
      end
      ST_SWEEP: begin
        if (hit) c0 <= c0 + CW'(1);
        if (x == x1) begin
          x    <= x0;
          y    <= y + 8'd1;
          base <= base + AW'(TILE_W);
        end else begin
          x <= x + 8'd1;
        end
      end
      ST_DRAIN: begin
        // Bit is one when the rank lies above all words with a zero here.
        if (k >= total) begin
          prefix <= prefix | cur;
          k      <= k - total;
        end
        mask <= mask | cur;
        cur  <= cur >> 1;
        c0   <= '0;
        x    <= x0;
        y    <= y0;
        base <= base0;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/tile_local_median_subtract.sv =====
// Top level of the tile local median subtract block.
// Instantiates the tile RAM and the rank sequencer; depends on tlms_pkg.
//
//  channel | signals                     | direction
//  req     | req_valid, req_stall, req   | in  (load or query word)
//  res     | res_valid, res_stall, res   | out (one word per query)
//  cfg     | cfg_valid, cfg_ready, cfg   | in  (window radius)
//
// A load writes the tile RAM directly. A query sweeps its window through the
// single tile RAM read port once in each of the 16 radix passes; disabled or
// outside queries skip the sweeps and go from the centre read to the result.
// Reset is synchronous and clears the radius and all control state.
// req_stall is high while a query is in progress; a finished word waits in
// the output register while res_stall is high.
module tile_local_median_subtract import tlms_pkg::*; #(
  parameter int TILE_W     = 194,
  parameter int TILE_H     = 185,
  parameter int MAX_RADIUS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RAD_W-1:0] cfg
);

  localparam int DEPTH = TILE_W * TILE_H;
  localparam int AW    = $clog2(DEPTH);

  logic [RAD_W-1:0] radius;
  logic             busy, done, take, accept, start, we;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [PIX_W-1:0] rd_data;
  res_t             rank_res;

  assign cfg_ready = 1'b1;
  assign req_stall = busy;
  assign accept    = req_valid && !req_stall;
  assign start     = accept && (req.action == ACT_QUERY);
  assign we        = accept && (req.action == ACT_LOAD)
                     && ({1'b0, req.col} < 9'(TILE_W)) && ({1'b0, req.row} < 9'(TILE_H));
  assign wr_addr   = AW'(req.row * TILE_W) + AW'(req.col);
  assign take      = done && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) radius <= cfg;
      if (take) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
    if (take) res <= rank_res;
  end

  tlms_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (req.pixel_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  tlms_rank #(
    .TILE_W     (TILE_W),
    .TILE_H     (TILE_H),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_rank (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .col     (req.col),
    .row     (req.row),
    .radius  (radius),
    .busy    (busy),
    .done    (done),
    .take    (take),
    .res     (rank_res),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== sim/tb_tile_local_median_subtract.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tile_local_median_subtract.
// Loads pixel patches, queries corrected pixels under several window radii and idle
// patterns, and checks every result word against an internal predictor. Needs tlms_pkg.
module tb_tile_local_median_subtract;
  import tlms_pkg::*;

  localparam int TW = 194;
  localparam int TH = 185;
  localparam int MAXR = 8;
  localparam int NPIX = TW * TH;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RAD_W-1:0] cfg = '0;

  tile_local_median_subtract uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg(cfg)
  );

  req_t pending_words[$];
  res_t expected_pixels[$];
  logic signed [PIX_W-1:0] tile_copy [0:NPIX-1];
  bit loaded_map [0:NPIX-1];
  logic [RAD_W-1:0] model_radius = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  int quiet_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Effective half width; 0 means subtraction is off.
  function automatic int eff_radius(logic [RAD_W-1:0] r);
    if (r == 0 || r >= TH / 2) return 0;
    return (r > MAXR) ? MAXR : int'(r);
  endfunction

  function automatic void predict_word(req_t w);
    int r, cnt, k, x, y, i, j, v;
    int vals [0:(2*MAXR+1)*(2*MAXR+1)-1];
    int centre, bg;
    res_t o;
    if (w.action == ACT_LOAD) begin
      if (w.col < TW && w.row < TH) tile_copy[w.row * TW + w.col] = w.pixel_value;
      return;
    end
    o = '0;
    if (w.col < TW && w.row < TH) begin
      centre = tile_copy[w.row * TW + w.col];
      r = eff_radius(model_radius);
      bg = 0;
      cnt = 0;
      if (r != 0) begin
        for (y = int'(w.row) - r; y <= int'(w.row) + r; y++)
          for (x = int'(w.col) - r; x <= int'(w.col) + r; x++)
            if (y >= 0 && y < TH && x >= 0 && x < TW) begin
              vals[cnt] = tile_copy[y * TW + x];
              cnt++;
            end
        for (i = 1; i < cnt; i++) begin
          v = vals[i];
          j = i - 1;
          while (j >= 0 && vals[j] > v) begin
            vals[j + 1] = vals[j];
            j--;
          end
          vals[j + 1] = v;
        end
        k = cnt / 2;
        bg = vals[k];
      end
      o.corrected = CORR_W'(centre - bg);
      o.background = PIX_W'(bg);
      o.window_count = CNT_W'(cnt);
    end
    expected_pixels.push_back(o);
  endfunction

  // Driver: a new word goes out only when the current one is taken or none is up.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req <= pending_words.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_go && hold_left == 0) begin
      hold_left <= LONG_HOLD;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin
    res_t e;
    if (!rst) begin
      if (req_valid && !req_stall) predict_word(req);
      if (res_valid && !res_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result word with nothing expected: %h", res);
          errors++;
        end else begin
          e = expected_pixels.pop_front();
          if (res.corrected !== e.corrected) begin
            $error("corrected: expected %0d, got %0d", e.corrected, res.corrected);
            errors++;
          end
          if (res.background !== e.background) begin
            $error("background: expected %0d, got %0d", e.background, res.background);
            errors++;
          end
          if (res.window_count !== e.window_count) begin
            $error("window_count: expected %0d, got %0d", e.window_count, res.window_count);
            errors++;
          end
        end
      end
      if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tile_local_median_subtract verification failed");
        $finish;
      end
    end
  end

  task automatic push_load(int c, int r, int v);
    req_t w;
    w.action = ACT_LOAD;
    w.col = c[7:0];
    w.row = r[7:0];
    w.pixel_value = v[15:0];
    if (c < TW && r < TH) loaded_map[r * TW + c] = 1'b1;
    pending_words.push_back(w);
  endtask

  task automatic push_query(int c, int r);
    req_t w;
    w.action = ACT_QUERY;
    w.col = c[7:0];
    w.row = r[7:0];
    w.pixel_value = PIX_W'($urandom());
    pending_words.push_back(w);
  endtask

  function automatic bit window_loaded(int c, int r, int rad);
    int x, y;
    for (y = r - rad; y <= r + rad; y++)
      for (x = c - rad; x <= c + rad; x++)
        if (y >= 0 && y < TH && x >= 0 && x < TW && !loaded_map[y * TW + x]) return 0;
    return 1;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || req_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_radius(logic [RAD_W-1:0] v);
    wait_drained();
    cfg <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_radius = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_pixel();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 7) - 4;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  // Random mix of loads and queries; queries only touch fully loaded windows.
  task automatic random_items(int n, int query_pct);
    int i, t, c, r, rad;
    bit ok;
    rad = eff_radius(model_radius);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) >= query_pct) begin
        case ($urandom_range(0, 19))
          0: push_load($urandom_range(0, 255), $urandom_range(TH, 255), rand_pixel());
          1: push_load($urandom_range(TW, 255), $urandom_range(0, 255), rand_pixel());
          2, 3, 4, 5: push_load($urandom_range(0, TW - 1), $urandom_range(0, TH - 1),
                                rand_pixel());
          6, 7, 8, 9, 10, 11: push_load($urandom_range(0, 17), $urandom_range(0, 17),
                                        rand_pixel());
          default: push_load($urandom_range(TW - 18, TW - 1), $urandom_range(TH - 18, TH - 1),
                             rand_pixel());
        endcase
      end else if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1)) push_query($urandom_range(TW, 255), $urandom_range(0, 255));
        else push_query($urandom_range(0, 255), $urandom_range(TH, 255));
      end else begin
        ok = 0;
        for (t = 0; t < 20 && !ok; t++) begin
          case ($urandom_range(0, 9))
            0, 1: begin
              c = $urandom_range(0, TW - 1);
              r = $urandom_range(0, TH - 1);
            end
            2, 3, 4, 5: begin
              c = $urandom_range(0, 17);
              r = $urandom_range(0, 17);
            end
            default: begin
              c = $urandom_range(TW - 18, TW - 1);
              r = $urandom_range(TH - 18, TH - 1);
            end
          endcase
          ok = window_loaded(c, r, rad);
        end
        if (ok) push_query(c, r);
        else push_query(8, 8);
      end
    end
  endtask

  task automatic run_phase(logic [RAD_W-1:0] rad, int idle_s, int idle_r, int n, int qpct);
    write_radius(rad);
    send_idle_pct = idle_s;
    recv_stall_pct = idle_r;
    random_items(n, qpct);
    wait_drained();
  endtask

  initial begin
    int c, r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill both corner patches so that any window there reads loaded pixels.
    for (r = 0; r < 18; r++)
      for (c = 0; c < 18; c++) begin
        push_load(c, r, rand_pixel());
        push_load(TW - 1 - c, TH - 1 - r, rand_pixel());
      end
    // Extreme values so that corrected reaches both ends of its range.
    push_load(0, 0, -32768);
    push_load(1, 0, 32767);
    push_load(0, 1, 32767);
    push_load(1, 1, 32767);
    push_load(TW - 1, TH - 1, 32767);
    push_load(TW - 2, TH - 1, -32768);
    push_load(TW - 1, TH - 2, -32768);
    push_load(TW - 2, TH - 2, -32768);
    push_load(255, 255, 1234);
    push_load(TW, 0, 55);
    push_load(0, TH, 66);
    // Radius at reset disables subtraction.
    push_query(0, 0);
    push_query(TW - 1, TH - 1);
    push_query(TW, 0);
    push_query(0, TH);
    push_query(255, 255);
    write_radius(4'd1);
    push_query(0, 0);
    push_query(TW - 1, TH - 1);
    push_query(TW, TH);
    write_radius(4'd8);
    push_query(0, 0);
    push_query(8, 8);
    push_query(TW - 1, TH - 1);
    write_radius(4'd15);
    push_query(8, 8);
    push_query(TW - 9, TH - 9);
    write_radius(4'd0);
    push_query(8, 8);

    run_phase(4'd1, 0, 0, 150, 40);
    run_phase(4'd2, 53, 0, 150, 40);
    run_phase(4'd3, 0, 53, 120, 40);
    run_phase(4'd1, 19, 19, 150, 40);
    run_phase(4'd0, 53, 53, 100, 50);

    // Long receiver hold while the sender keeps offering words.
    write_radius(4'd1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_items(60, 60);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    wait_drained();

    run_phase(4'd2, 0, 0, 150, 40);
    run_phase(4'd8, 19, 19, 20, 50);
    run_phase(4'd12, 0, 53, 12, 50);
    run_phase(4'd4, 53, 0, 100, 30);
    run_phase(4'd1, 0, 0, 100, 50);

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tile_local_median_subtract verification clean");
    else $display("tile_local_median_subtract verification failed");
    $finish;
  end

endmodule
